FILE: design/mkh_pkg.sv
// shared types, codes and helpers for the multilinear kinematic hysteresis block
// no dependencies
package mkh_pkg;

  localparam logic [2:0] OP_LOAD         = 3'd0;
  localparam logic [2:0] OP_TRIAL        = 3'd1;
  localparam logic [2:0] OP_COMMIT       = 3'd2;
  localparam logic [2:0] OP_REVERT_LAST  = 3'd3;
  localparam logic [2:0] OP_REVERT_START = 3'd4;

  localparam int SPAN_W  = 33;
  localparam int MUL_A_W = 34;
  localparam int TAN_W   = 48;
  localparam int SUM_W   = 40;
  localparam int DIV_N_W = 61;
  localparam int DIV_D_W = 33;
  localparam int FRAC_SH = 28;
  localparam int MUL_CHUNK = 16;
  localparam int MUL_STEPS = TAN_W / MUL_CHUNK;

  localparam logic [4:0] CMD_NOP      = 5'd0;
  localparam logic [4:0] CMD_CAPTURE  = 5'd1;
  localparam logic [4:0] CMD_LOAD_BAD = 5'd2;
  localparam logic [4:0] CMD_LOAD_ST  = 5'd3;
  localparam logic [4:0] CMD_LOAD_WR  = 5'd4;
  localparam logic [4:0] CMD_TR_CLASS = 5'd5;
  localparam logic [4:0] CMD_TR_INC   = 5'd6;
  localparam logic [4:0] CMD_TR_PICK  = 5'd7;
  localparam logic [4:0] CMD_TR_START = 5'd8;
  localparam logic [4:0] CMD_TR_WR    = 5'd9;
  localparam logic [4:0] CMD_CM_INIT  = 5'd10;
  localparam logic [4:0] CMD_CM_STRN  = 5'd11;
  localparam logic [4:0] CMD_CM_START = 5'd12;
  localparam logic [4:0] CMD_CM_WR    = 5'd13;
  localparam logic [4:0] CMD_CM_COPY  = 5'd14;
  localparam logic [4:0] CMD_RL_COPY  = 5'd15;
  localparam logic [4:0] CMD_RV_INIT  = 5'd16;
  localparam logic [4:0] CMD_RV_START = 5'd17;
  localparam logic [4:0] CMD_RV_WR    = 5'd18;
  localparam logic [4:0] CMD_OUT_LOAD = 5'd19;

  typedef struct packed {
    logic [4:0] code;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       load_bad;
    logic       x_eq;
    logic       t_zero;
    logic       tr_mid;
    logic       scan_more;
    logic       mul_done;
    logic       div_done;
    logic       idx_last;
    logic       out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(40'sh007FFFFFFF)) r = 32'sh7FFFFFFF;
    else if (v < $signed(40'shFF80000000)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: design/mkh_mul.sv
// sequential saturating fixed-point multiplier: (a * b) >> 28, truncated, 32-bit result
// uses mkh_pkg
module mkh_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [mkh_pkg::MUL_A_W-1:0] a,
  input  logic signed [mkh_pkg::TAN_W-1:0]   b,
  output logic                               done,
  output logic signed [31:0]                 p
);

  localparam int AW  = mkh_pkg::MUL_A_W;
  localparam int BW  = mkh_pkg::TAN_W;
  localparam int CH  = mkh_pkg::MUL_CHUNK;
  localparam int ACW = AW + BW;
  localparam int RW  = ACW - mkh_pkg::FRAC_SH;

  logic [AW-1:0]      ua_r;
  logic [BW-1:0]      ub_r;
  logic               neg_r;
  logic [ACW-1:0]     acc_r;
  logic [1:0]         cnt_r;
  logic               busy_r;
  logic               fin_r;
  logic               done_r;
  logic signed [31:0] p_r;
  logic [AW+CH-1:0]   pp;
  logic [RW-1:0]      mag;

  assign pp  = ua_r * ub_r[BW-1 -: CH];
  assign mag = acc_r[ACW-1:mkh_pkg::FRAC_SH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        neg_r  <= a[AW-1] ^ b[BW-1];
        ua_r   <= a[AW-1] ? AW'(-a) : AW'(a);
        ub_r   <= b[BW-1] ? BW'(-b) : BW'(b);
      end else if (busy_r) begin
        // most significant chunk first
        acc_r <= (acc_r << CH) + ACW'(pp);
        ub_r  <= ub_r << CH;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'(mkh_pkg::MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        if (neg_r) begin
          if (mag > RW'(64'd2147483648)) p_r <= 32'sh80000000;
          else p_r <= 32'(~mag + RW'(1));
        end else begin
          if (mag > RW'(64'd2147483647)) p_r <= 32'sh7FFFFFFF;
          else p_r <= 32'(mag);
        end
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

FILE: design/mkh_div.sv
// restoring divider, one quotient bit per cycle, unsigned operands
// uses mkh_pkg
module mkh_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mkh_pkg::DIV_N_W-1:0]   num,
  input  logic [mkh_pkg::DIV_D_W-1:0]   den,
  output logic                          done,
  output logic [mkh_pkg::DIV_N_W-1:0]   quo
);

  localparam int NW = mkh_pkg::DIV_N_W;
  localparam int DW = mkh_pkg::DIV_D_W;

  logic [NW-1:0] q_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted = {rem_r, q_r[NW-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? DW'(shifted - {1'b0, den_r}) : DW'(shifted);
        q_r   <= {q_r[NW-2:0], fits};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

FILE: design/mkh_dp.sv
// datapath: segment table, trial and committed state, result register
// uses mkh_pkg, mkh_mul, mkh_div
module mkh_dp #(
  parameter int MAX_SEGMENTS = 8,
  parameter int IW = 3,
  parameter int CW = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mkh_pkg::cmd_t         cmd,
  output mkh_pkg::status_t      st,
  input  logic [2:0]            in_opcode,
  input  logic signed [31:0]    in_strain_in,
  input  logic signed [31:0]    in_point_stress,
  input  logic [2:0]            in_point_index,
  input  logic                  cfg_valid,
  input  logic [3:0]            cfg_segment_count,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic signed [31:0]    out_stress_out,
  output logic signed [47:0]    out_tangent_out,
  output logic [2:0]            out_active_segment,
  output logic                  out_error_flag
);

  localparam int XW  = (CW > 3) ? CW : 3;
  localparam int TW  = (IW > 3) ? IW : 3;
  localparam int SW  = mkh_pkg::SPAN_W;
  localparam int AW  = mkh_pkg::MUL_A_W;
  localparam int GW  = mkh_pkg::TAN_W;
  localparam int UW  = mkh_pkg::SUM_W;
  localparam int NW  = mkh_pkg::DIV_N_W;

  // segment table
  logic signed [31:0]   nbe_r  [MAX_SEGMENTS];
  logic signed [31:0]   pbe_r  [MAX_SEGMENTS];
  logic signed [31:0]   nbs_r  [MAX_SEGMENTS];
  logic signed [31:0]   pbs_r  [MAX_SEGMENTS];
  logic signed [GW-1:0] slope_r[MAX_SEGMENTS];
  logic signed [SW-1:0] span_r [MAX_SEGMENTS];

  logic [3:0]           segcnt_r;
  logic [2:0]           op_r;
  logic signed [31:0]   x_r;
  logic signed [31:0]   s_r;
  logic [2:0]           pidx_r;
  logic [CW-1:0]        idx_r;
  logic [CW-1:0]        last_r;
  logic                 side_r;
  logic                 dir_r;
  logic                 err_r;
  logic                 ldneg_r;
  logic signed [SW-1:0] lspan_r;
  logic signed [31:0]   cs_r;
  logic signed [31:0]   prev_nbe_r, prev_pbe_r, prev_nbs_r, prev_pbs_r;

  logic signed [31:0]   ts_strain_r, ts_stress_r;
  logic signed [GW-1:0] ts_tan_r;
  logic [IW-1:0]        tseg_r;
  logic signed [31:0]   cm_strain_r, cm_stress_r;
  logic signed [GW-1:0] cm_tan_r;

  logic                 out_valid_r;
  logic signed [31:0]   o_stress_r;
  logic signed [GW-1:0] o_tan_r;
  logic [2:0]           o_seg_r;
  logic                 o_err_r;

  logic [CW-1:0]        n_eff;
  logic [IW-1:0]        ri;
  logic [IW-1:0]        wi;
  logic [XW-1:0]        pidx_x;
  logic [TW-1:0]        tseg_x;
  logic signed [31:0]   rd_nbe, rd_pbe, rd_nbs, rd_pbs;
  logic signed [GW-1:0] rd_slope;
  logic signed [SW-1:0] rd_span;

  logic signed [31:0]   pe, ps;
  logic signed [SW-1:0] l_span, l_ds;
  logic [SW-1:0]        ds_mag;
  logic                 load_bad;
  logic signed [GW-1:0] slope_new;

  logic                 tr_mid, tr_neg, scan_more;
  logic signed [AW-1:0] span2;
  logic                 type_a;
  logic signed [UW-1:0] cm_sum;
  logic signed [31:0]   cm_stress_new;
  logic signed [31:0]   rv_pb, rv_ps;
  logic [CW-1:0]        t_ext, cm_end;

  logic                 mul_start;
  logic signed [AW-1:0] mul_a;
  logic                 mul_done;
  logic signed [31:0]   mul_p;
  logic                 div_start;
  logic                 div_done;
  logic [NW-1:0]        div_q;

  always_comb begin
    if (segcnt_r == 4'd0) n_eff = CW'(1);
    else if (int'(segcnt_r) > MAX_SEGMENTS) n_eff = CW'(MAX_SEGMENTS);
    else n_eff = CW'(segcnt_r);
  end

  assign ri       = idx_r[IW-1:0];
  assign pidx_x   = XW'(pidx_r);
  assign wi       = pidx_x[IW-1:0];
  assign tseg_x   = TW'(tseg_r);
  assign rd_nbe   = nbe_r[ri];
  assign rd_pbe   = pbe_r[ri];
  assign rd_nbs   = nbs_r[ri];
  assign rd_pbs   = pbs_r[ri];
  assign rd_slope = slope_r[ri];
  assign rd_span  = span_r[ri];

  // load_point: previous point is entry idx, or the origin for index zero
  assign pe       = (pidx_r == 3'd0) ? 32'sd0 : rd_pbe;
  assign ps       = (pidx_r == 3'd0) ? 32'sd0 : rd_pbs;
  assign l_span   = SW'(x_r) - SW'(pe);
  assign l_ds     = SW'(s_r) - SW'(ps);
  assign ds_mag   = l_ds[SW-1] ? SW'(-l_ds) : SW'(l_ds);
  assign load_bad = (pidx_x >= XW'(n_eff)) || (x_r <= pe);

  always_comb begin
    if (ldneg_r) begin
      if (div_q > NW'(64'h800000000000)) slope_new = {1'b1, {(GW-1){1'b0}}};
      else slope_new = GW'(-div_q);
    end else begin
      if (div_q > NW'(64'h7FFFFFFFFFFF)) slope_new = {1'b0, {(GW-1){1'b1}}};
      else slope_new = GW'(div_q);
    end
  end

  // trial search
  assign tr_mid    = (x_r >= rd_nbe) && (x_r <= rd_pbe);
  assign tr_neg    = x_r < rd_nbe;
  assign scan_more = (idx_r < n_eff) && (side_r ? (x_r > rd_pbe) : (x_r < rd_nbe));

  // commit: segments below the trial segment move with the load point,
  // the rest keep their spans relative to the shifted neighbor
  assign span2  = {rd_span, 1'b0};
  assign t_ext  = CW'(tseg_r);
  assign type_a = idx_r < t_ext;
  assign cm_end = ((t_ext > n_eff) ? t_ext : n_eff) - CW'(1);

  always_comb begin
    if (dir_r) begin
      cm_sum = UW'(prev_nbe_r) - UW'(span2);
      if (!type_a) cm_sum = cm_sum + UW'(rd_pbe) - UW'(prev_pbe_r);
    end else begin
      cm_sum = UW'(prev_pbe_r) + UW'(span2);
      if (!type_a) cm_sum = cm_sum + UW'(rd_nbe) - UW'(prev_nbe_r);
    end
  end

  always_comb begin
    if (dir_r && type_a) cm_stress_new = mkh_pkg::sat32(UW'(prev_nbs_r) - UW'(mul_p));
    else if (dir_r) cm_stress_new = mkh_pkg::sat32(UW'(prev_nbs_r) + UW'(mul_p));
    else cm_stress_new = mkh_pkg::sat32(UW'(prev_pbs_r) + UW'(mul_p));
  end

  assign rv_pb = mkh_pkg::sat32(UW'(prev_pbe_r) + UW'(rd_span));
  assign rv_ps = mkh_pkg::sat32(UW'(prev_pbs_r) + UW'(mul_p));

  always_comb begin
    mul_start = 1'b0;
    mul_a     = AW'(rd_span);
    case (cmd.code)
      mkh_pkg::CMD_TR_START: begin
        mul_start = 1'b1;
        mul_a     = AW'(x_r) - AW'(side_r ? rd_pbe : rd_nbe);
      end
      mkh_pkg::CMD_CM_START: begin
        mul_start = 1'b1;
        if (type_a) mul_a = span2;
        else mul_a = AW'(cs_r) - AW'(dir_r ? prev_nbe_r : prev_pbe_r);
      end
      mkh_pkg::CMD_RV_START: begin
        mul_start = 1'b1;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign div_start = (cmd.code == mkh_pkg::CMD_LOAD_ST);

  mkh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (rd_slope),
    .done  (mul_done),
    .p     (mul_p)
  );

  mkh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({ds_mag, {mkh_pkg::FRAC_SH{1'b0}}}),
    .den   (l_span),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) segcnt_r <= 4'd1;
    else if (cfg_valid) segcnt_r <= cfg_segment_count;
  end

  // table writes
  always_ff @(posedge clk) begin
    case (cmd.code)
      mkh_pkg::CMD_LOAD_WR: begin
        nbe_r[wi]   <= -x_r;
        pbe_r[wi]   <= x_r;
        nbs_r[wi]   <= mkh_pkg::sat32(-UW'(s_r));
        pbs_r[wi]   <= s_r;
        slope_r[wi] <= slope_new;
        span_r[wi]  <= lspan_r;
      end
      mkh_pkg::CMD_CM_WR: begin
        if (dir_r) begin
          nbe_r[ri] <= cs_r;
          nbs_r[ri] <= cm_stress_new;
          if (type_a) begin
            pbe_r[ri] <= ts_strain_r;
            pbs_r[ri] <= ts_stress_r;
          end
        end else begin
          pbe_r[ri] <= cs_r;
          pbs_r[ri] <= cm_stress_new;
          if (type_a) begin
            nbe_r[ri] <= ts_strain_r;
            nbs_r[ri] <= ts_stress_r;
          end
        end
      end
      mkh_pkg::CMD_RV_WR: begin
        pbe_r[ri] <= rv_pb;
        pbs_r[ri] <= rv_ps;
        nbe_r[ri] <= mkh_pkg::sat32(-UW'(rv_pb));
        nbs_r[ri] <= mkh_pkg::sat32(-UW'(rv_ps));
      end
      default: begin
      end
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.code)
      mkh_pkg::CMD_CAPTURE: begin
        op_r   <= in_opcode;
        x_r    <= in_strain_in;
        s_r    <= in_point_stress;
        pidx_r <= in_point_index;
        if (in_opcode == mkh_pkg::OP_LOAD && in_point_index != 3'd0)
          idx_r <= CW'(XW'(in_point_index) - XW'(1));
        else
          idx_r <= '0;
      end
      mkh_pkg::CMD_LOAD_ST: begin
        lspan_r <= l_span;
        ldneg_r <= l_ds[SW-1];
      end
      mkh_pkg::CMD_TR_CLASS: begin
        side_r <= !tr_mid && !tr_neg;
        if (!tr_mid) idx_r <= CW'(1);
      end
      mkh_pkg::CMD_TR_INC: idx_r <= idx_r + CW'(1);
      mkh_pkg::CMD_TR_PICK: begin
        if (idx_r >= n_eff) idx_r <= n_eff - CW'(1);
      end
      mkh_pkg::CMD_CM_INIT: begin
        dir_r      <= ts_strain_r > rd_pbe;
        last_r     <= cm_end;
        prev_nbe_r <= ts_strain_r;
        prev_pbe_r <= ts_strain_r;
        prev_nbs_r <= ts_stress_r;
        prev_pbs_r <= ts_stress_r;
      end
      mkh_pkg::CMD_CM_STRN: cs_r <= mkh_pkg::sat32(cm_sum);
      mkh_pkg::CMD_CM_WR: begin
        idx_r <= idx_r + CW'(1);
        if (dir_r) begin
          prev_nbe_r <= cs_r;
          prev_nbs_r <= cm_stress_new;
          prev_pbe_r <= type_a ? ts_strain_r : rd_pbe;
          prev_pbs_r <= type_a ? ts_stress_r : rd_pbs;
        end else begin
          prev_pbe_r <= cs_r;
          prev_pbs_r <= cm_stress_new;
          prev_nbe_r <= type_a ? ts_strain_r : rd_nbe;
          prev_nbs_r <= type_a ? ts_stress_r : rd_nbs;
        end
      end
      mkh_pkg::CMD_RV_INIT: begin
        idx_r      <= '0;
        last_r     <= n_eff - CW'(1);
        prev_pbe_r <= 32'sd0;
        prev_pbs_r <= 32'sd0;
      end
      mkh_pkg::CMD_RV_WR: begin
        idx_r      <= idx_r + CW'(1);
        prev_pbe_r <= rv_pb;
        prev_pbs_r <= rv_ps;
      end
      default: begin
      end
    endcase
  end

  // trial and committed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_strain_r <= '0;
      ts_stress_r <= '0;
      ts_tan_r    <= '0;
      tseg_r      <= '0;
      cm_strain_r <= '0;
      cm_stress_r <= '0;
      cm_tan_r    <= '0;
      err_r       <= 1'b0;
    end else begin
      case (cmd.code)
        mkh_pkg::CMD_CAPTURE: err_r <= 1'b0;
        mkh_pkg::CMD_LOAD_BAD: err_r <= 1'b1;
        mkh_pkg::CMD_LOAD_WR: begin
          if (pidx_r == 3'd0) begin
            ts_tan_r <= slope_new;
            cm_tan_r <= slope_new;
          end
        end
        mkh_pkg::CMD_TR_WR: begin
          ts_strain_r <= x_r;
          ts_stress_r <= mkh_pkg::sat32(UW'(side_r ? rd_pbs : rd_nbs) + UW'(mul_p));
          ts_tan_r    <= rd_slope;
          tseg_r      <= ri;
        end
        mkh_pkg::CMD_CM_WR: begin
          if (idx_r == last_r) begin
            cm_strain_r <= ts_strain_r;
            cm_stress_r <= ts_stress_r;
            cm_tan_r    <= ts_tan_r;
          end
        end
        mkh_pkg::CMD_CM_COPY: begin
          cm_strain_r <= ts_strain_r;
          cm_stress_r <= ts_stress_r;
          cm_tan_r    <= ts_tan_r;
        end
        mkh_pkg::CMD_RL_COPY: begin
          ts_strain_r <= cm_strain_r;
          ts_stress_r <= cm_stress_r;
          ts_tan_r    <= cm_tan_r;
        end
        mkh_pkg::CMD_RV_WR: begin
          if (idx_r == last_r) begin
            ts_strain_r <= '0;
            ts_stress_r <= '0;
            cm_strain_r <= '0;
            cm_stress_r <= '0;
            ts_tan_r    <= slope_r[0];
            cm_tan_r    <= slope_r[0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.code == mkh_pkg::CMD_OUT_LOAD) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.code == mkh_pkg::CMD_OUT_LOAD) begin
      o_stress_r <= ts_stress_r;
      o_tan_r    <= ts_tan_r;
      o_seg_r    <= tseg_x[2:0];
      o_err_r    <= err_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_stress_out     = o_stress_r;
  assign out_tangent_out    = o_tan_r;
  assign out_active_segment = o_seg_r;
  assign out_error_flag     = o_err_r;

  assign st.op        = op_r;
  assign st.load_bad  = load_bad;
  assign st.x_eq      = x_r == ts_strain_r;
  assign st.t_zero    = tseg_r == '0;
  assign st.tr_mid    = tr_mid;
  assign st.scan_more = scan_more;
  assign st.mul_done  = mul_done;
  assign st.div_done  = div_done;
  assign st.idx_last  = idx_r == last_r;
  assign st.out_free  = !out_valid_r || !out_stall;

endmodule

FILE: design/mkh_ctrl.sv
// controller: sequences one word at a time through the datapath
// uses mkh_pkg
module mkh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mkh_pkg::status_t  st,
  output mkh_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_LDIV   = 4'd2;
  localparam logic [3:0] S_TSCAN  = 4'd3;
  localparam logic [3:0] S_TSTART = 4'd4;
  localparam logic [3:0] S_TMUL   = 4'd5;
  localparam logic [3:0] S_CSTRN  = 4'd6;
  localparam logic [3:0] S_CSTART = 4'd7;
  localparam logic [3:0] S_CMUL   = 4'd8;
  localparam logic [3:0] S_RSTART = 4'd9;
  localparam logic [3:0] S_RMUL   = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd.code  = mkh_pkg::CMD_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.code  = mkh_pkg::CMD_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st.op)
          mkh_pkg::OP_LOAD: begin
            if (st.load_bad) begin
              cmd.code  = mkh_pkg::CMD_LOAD_BAD;
              state_nxt = S_FIN;
            end else begin
              cmd.code  = mkh_pkg::CMD_LOAD_ST;
              state_nxt = S_LDIV;
            end
          end
          mkh_pkg::OP_TRIAL: begin
            if (st.x_eq) begin
              state_nxt = S_FIN;
            end else begin
              cmd.code  = mkh_pkg::CMD_TR_CLASS;
              state_nxt = st.tr_mid ? S_TSTART : S_TSCAN;
            end
          end
          mkh_pkg::OP_COMMIT: begin
            if (st.t_zero) begin
              cmd.code  = mkh_pkg::CMD_CM_COPY;
              state_nxt = S_FIN;
            end else begin
              cmd.code  = mkh_pkg::CMD_CM_INIT;
              state_nxt = S_CSTRN;
            end
          end
          mkh_pkg::OP_REVERT_LAST: begin
            cmd.code  = mkh_pkg::CMD_RL_COPY;
            state_nxt = S_FIN;
          end
          mkh_pkg::OP_REVERT_START: begin
            cmd.code  = mkh_pkg::CMD_RV_INIT;
            state_nxt = S_RSTART;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_LDIV: begin
        if (st.div_done) begin
          cmd.code  = mkh_pkg::CMD_LOAD_WR;
          state_nxt = S_FIN;
        end
      end
      S_TSCAN: begin
        if (st.scan_more) begin
          cmd.code = mkh_pkg::CMD_TR_INC;
        end else begin
          cmd.code  = mkh_pkg::CMD_TR_PICK;
          state_nxt = S_TSTART;
        end
      end
      S_TSTART: begin
        cmd.code  = mkh_pkg::CMD_TR_START;
        state_nxt = S_TMUL;
      end
      S_TMUL: begin
        if (st.mul_done) begin
          cmd.code  = mkh_pkg::CMD_TR_WR;
          state_nxt = S_FIN;
        end
      end
      S_CSTRN: begin
        cmd.code  = mkh_pkg::CMD_CM_STRN;
        state_nxt = S_CSTART;
      end
      S_CSTART: begin
        cmd.code  = mkh_pkg::CMD_CM_START;
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        if (st.mul_done) begin
          cmd.code  = mkh_pkg::CMD_CM_WR;
          state_nxt = st.idx_last ? S_FIN : S_CSTRN;
        end
      end
      S_RSTART: begin
        cmd.code  = mkh_pkg::CMD_RV_START;
        state_nxt = S_RMUL;
      end
      S_RMUL: begin
        if (st.mul_done) begin
          cmd.code  = mkh_pkg::CMD_RV_WR;
          state_nxt = st.idx_last ? S_FIN : S_RSTART;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.code  = mkh_pkg::CMD_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: design/multilinear_kinematic_hysteresis.sv
// one word at a time; a result leaves through an output register, so the next word
// is taken while the last result still waits. load_point runs a 61-step serial
// divider; trial, commit and revert_to_start use the serial multiplier, commit
// and revert_to_start once per segment; other operations use neither.
// reset clears trial and committed state and sets segment_count to 1; the segment
// table is undefined until points are loaded
module multilinear_kinematic_hysteresis #(
  parameter int MAX_SEGMENTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_strain_in,
  input  logic signed [31:0] in_point_stress,
  input  logic [2:0]         in_point_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_stress_out,
  output logic signed [47:0] out_tangent_out,
  output logic [2:0]         out_active_segment,
  output logic               out_error_flag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_segment_count
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  mkh_pkg::cmd_t    cmd;
  mkh_pkg::status_t st;

  assign cfg_ready = 1'b1;

  mkh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mkh_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .IW           (IW),
    .CW           (CW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_opcode          (in_opcode),
    .in_strain_in       (in_strain_in),
    .in_point_stress    (in_point_stress),
    .in_point_index     (in_point_index),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_segment_count  (cfg_segment_count),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_stress_out     (out_stress_out),
    .out_tangent_out    (out_tangent_out),
    .out_active_segment (out_active_segment),
    .out_error_flag     (out_error_flag)
  );

endmodule

FILE: design/mkh_checker.sv
// port-level checks for multilinear_kinematic_hysteresis, attached with bind
// no dependencies
module mkh_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_stress_out,
  input logic signed [47:0] out_tangent_out
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_stress_out) && $stable(out_tangent_out))
    else $error("stalled result changed");

  // one word in flight: after an accept the input side is busy
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // a new result only comes out of work on an accepted word
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

endmodule

bind multilinear_kinematic_hysteresis mkh_checker u_mkh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_stress_out  (out_stress_out),
  .out_tangent_out (out_tangent_out)
);

FILE: verif/tb_top.sv
// self-checking testbench for multilinear_kinematic_hysteresis: a queued driver,
// an output monitor and a fixed-point hysteresis predictor
// depends on design/mkh_pkg.sv and design/multilinear_kinematic_hysteresis.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NSEG = 8;
  localparam longint CYCLE_LIMIT = 800000;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] strain;
    logic signed [31:0] stress;
    logic [2:0]         idx;
  } word_t;

  typedef struct {
    logic signed [31:0] stress;
    logic signed [47:0] tangent;
    logic [2:0]         seg;
    logic               err;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = '0;
  logic signed [31:0] in_strain_in = '0;
  logic signed [31:0] in_point_stress = '0;
  logic [2:0] in_point_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_stress_out;
  logic signed [47:0] out_tangent_out;
  logic [2:0] out_active_segment;
  logic out_error_flag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_segment_count = 4'd1;

  multilinear_kinematic_hysteresis u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_strain_in(in_strain_in), .in_point_stress(in_point_stress),
    .in_point_index(in_point_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_stress_out(out_stress_out),
    .out_tangent_out(out_tangent_out), .out_active_segment(out_active_segment),
    .out_error_flag(out_error_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_segment_count(cfg_segment_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hysteresis state mirror
  longint neg_e[NSEG], pos_e[NSEG], neg_s[NSEG], pos_s[NSEG], slope[NSEG], span[NSEG];
  longint tr_strain, tr_stress, tr_tangent, cm_strain, cm_stress, cm_tangent;
  int unsigned tr_seg;
  logic [3:0] seg_count_reg = 4'd1;

  word_t pending[$];
  resp_t expected_q[$];
  word_t cur_word;
  int accepted = 0;
  int send_idle_pct = 30, recv_idle_pct = 52;
  int fail_count = 0;
  longint cycles = 0;

  function automatic longint clamp32(longint v);
    return v > I32_MAX ? I32_MAX : (v < I32_MIN ? I32_MIN : v);
  endfunction

  function automatic longint clamp48(longint v);
    longint hi;
    hi = (64'sd1 <<< 47) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  // (a * b) >> 28 with the magnitude truncated, saturated to 32 bit
  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] p;
    logic [127:0] mag, r;
    p = 128'(signed'(a)) * 128'(signed'(b));
    mag = p < 0 ? -p : p;
    r = mag >> mkh_pkg::FRAC_SH;
    if (p >= 0) return r > 128'(I32_MAX) ? I32_MAX : longint'(r);
    return r > 128'h80000000 ? I32_MIN : -longint'(r);
  endfunction

  function automatic int unsigned seg_limit();
    if (seg_count_reg == 0) return 1;
    if (seg_count_reg > NSEG) return NSEG;
    return seg_count_reg;
  endfunction

  task automatic predict_word(input word_t w);
    longint x, s, pe, ps;
    int unsigned n, k, t, i;
    resp_t r;
    n = seg_limit();
    x = w.strain;
    s = w.stress;
    r.err = 1'b0;
    case (w.op)
      mkh_pkg::OP_LOAD: begin
        pe = 0;
        ps = 0;
        if (w.idx > 0) begin
          pe = pos_e[w.idx - 1];
          ps = pos_s[w.idx - 1];
        end
        if (w.idx >= n || x <= pe) r.err = 1'b1;
        else begin
          neg_e[w.idx] = -x;
          pos_e[w.idx] = x;
          neg_s[w.idx] = clamp32(-s);
          pos_s[w.idx] = s;
          slope[w.idx] = clamp48(((s - ps) * 268435456) / (x - pe));
          span[w.idx] = x - pe;
          if (w.idx == 0) begin
            tr_tangent = slope[0];
            cm_tangent = slope[0];
          end
        end
      end
      mkh_pkg::OP_TRIAL: begin
        if (x != tr_strain) begin
          tr_strain = x;
          if (x >= neg_e[0] && x <= pos_e[0]) begin
            k = 0;
            tr_stress = clamp32(neg_s[0] + qmul(x - neg_e[0], slope[0]));
          end else if (x < neg_e[0]) begin
            k = 1;
            while (k < n && x < neg_e[k]) k++;
            if (k >= n) k = n - 1;
            tr_stress = clamp32(neg_s[k] + qmul(x - neg_e[k], slope[k]));
          end else begin
            k = 1;
            while (k < n && x > pos_e[k]) k++;
            if (k >= n) k = n - 1;
            tr_stress = clamp32(pos_s[k] + qmul(x - pos_e[k], slope[k]));
          end
          tr_tangent = slope[k];
          tr_seg = k;
        end
      end
      mkh_pkg::OP_COMMIT: begin
        t = tr_seg;
        if (t != 0) begin
          if (tr_strain > pos_e[0]) begin
            pos_e[0] = tr_strain;
            pos_s[0] = tr_stress;
            neg_e[0] = clamp32(tr_strain - 2 * span[0]);
            neg_s[0] = clamp32(tr_stress - qmul(2 * span[0], slope[0]));
            for (i = 1; i < t; i++) begin
              pos_e[i] = tr_strain;
              pos_s[i] = tr_stress;
              neg_e[i] = clamp32(neg_e[i-1] - 2 * span[i]);
              neg_s[i] = clamp32(neg_s[i-1] - qmul(2 * span[i], slope[i]));
            end
            for (i = t; i < n; i++) begin
              neg_e[i] = clamp32(neg_e[i-1] - 2 * span[i] + pos_e[i] - pos_e[i-1]);
              neg_s[i] = clamp32(neg_s[i-1] + qmul(neg_e[i] - neg_e[i-1], slope[i]));
            end
          end else begin
            neg_e[0] = tr_strain;
            neg_s[0] = tr_stress;
            pos_e[0] = clamp32(tr_strain + 2 * span[0]);
            pos_s[0] = clamp32(tr_stress + qmul(2 * span[0], slope[0]));
            for (i = 1; i < t; i++) begin
              neg_e[i] = tr_strain;
              neg_s[i] = tr_stress;
              pos_e[i] = clamp32(pos_e[i-1] + 2 * span[i]);
              pos_s[i] = clamp32(pos_s[i-1] + qmul(2 * span[i], slope[i]));
            end
            for (i = t; i < n; i++) begin
              pos_e[i] = clamp32(pos_e[i-1] + 2 * span[i] + neg_e[i] - neg_e[i-1]);
              pos_s[i] = clamp32(pos_s[i-1] + qmul(pos_e[i] - pos_e[i-1], slope[i]));
            end
          end
        end
        cm_strain = tr_strain;
        cm_stress = tr_stress;
        cm_tangent = tr_tangent;
      end
      mkh_pkg::OP_REVERT_LAST: begin
        tr_strain = cm_strain;
        tr_stress = cm_stress;
        tr_tangent = cm_tangent;
      end
      mkh_pkg::OP_REVERT_START: begin
        pos_e[0] = clamp32(span[0]);
        pos_s[0] = qmul(span[0], slope[0]);
        neg_e[0] = clamp32(-pos_e[0]);
        neg_s[0] = clamp32(-pos_s[0]);
        for (i = 1; i < n; i++) begin
          pos_e[i] = clamp32(pos_e[i-1] + span[i]);
          pos_s[i] = clamp32(pos_s[i-1] + qmul(span[i], slope[i]));
          neg_e[i] = clamp32(-pos_e[i]);
          neg_s[i] = clamp32(-pos_s[i]);
        end
        tr_strain = 0;
        cm_strain = 0;
        tr_stress = 0;
        cm_stress = 0;
        tr_tangent = slope[0];
        cm_tangent = slope[0];
      end
      default: ;
    endcase
    r.stress = tr_stress[31:0];
    r.tangent = tr_tangent[47:0];
    r.seg = tr_seg[2:0];
    expected_q.push_back(r);
  endtask

  // driver: a word is held while stalled, otherwise the next one may be delayed
  always @(posedge clk) begin : drive
    word_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_word(cur_word);
        accepted++;
        if (accepted == 220) begin
          send_idle_pct = 52;
          recv_idle_pct = 30;
        end else if (accepted == 440) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      end
      if (!(in_valid && in_stall)) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending.pop_front();
          cur_word = nxt;
          in_valid <= 1'b1;
          in_opcode <= nxt.op;
          in_strain_in <= nxt.strain;
          in_point_stress <= nxt.stress;
          in_point_index <= nxt.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    resp_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_stress_out !== e.stress) begin
            $error("stress_out expected %0d got %0d", e.stress, out_stress_out);
            fail_count++;
          end
          if (out_tangent_out !== e.tangent) begin
            $error("tangent_out expected %0d got %0d", e.tangent, out_tangent_out);
            fail_count++;
          end
          if (out_active_segment !== e.seg) begin
            $error("active_segment expected %0d got %0d", e.seg, out_active_segment);
            fail_count++;
          end
          if (out_error_flag !== e.err) begin
            $error("error_flag expected %0d got %0d", e.err, out_error_flag);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic word_t mk(logic [2:0] op, logic signed [31:0] e,
                               logic signed [31:0] s, logic [2:0] i);
    word_t w;
    w.op = op;
    w.strain = e;
    w.stress = s;
    w.idx = i;
    return w;
  endfunction

  task automatic settle();
    while (pending.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_count(logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_segment_count <= v;
    do @(posedge clk); while (!cfg_ready);
    seg_count_reg = v;
    cfg_valid <= 1'b0;
  endtask

  // queue a fresh increasing backbone of n points; returns the last point strain
  task automatic queue_backbone(int unsigned n, output longint top);
    longint e, s;
    int unsigned i;
    e = 0;
    s = 0;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) e = e + 1;
      else e = e + $urandom_range(32'h0800_0000, 1);
      if ($urandom_range(9) == 0) s = $signed($urandom);
      else s = s + ($urandom_range(32'h0010_0000, 1) >> i);
      pending.push_back(mk(mkh_pkg::OP_LOAD, e[31:0], s[31:0], i[2:0]));
    end
    top = e;
  endtask

  task automatic queue_random(int count);
    int unsigned pick;
    logic signed [31:0] x;
    for (int j = 0; j < count; j++) begin
      pick = $urandom_range(99);
      x = $signed($urandom) >>> $urandom_range(4, 1);
      if ($urandom_range(9) == 0) x = $urandom;
      if (pick < 50)
        pending.push_back(mk(mkh_pkg::OP_TRIAL, x, $urandom, 3'($urandom)));
      else if (pick < 68)
        pending.push_back(mk(mkh_pkg::OP_COMMIT, $urandom, $urandom, 3'($urandom)));
      else if (pick < 76)
        pending.push_back(mk(mkh_pkg::OP_REVERT_LAST, x, $urandom, 3'($urandom)));
      else if (pick < 81)
        pending.push_back(mk(mkh_pkg::OP_REVERT_START, x, $urandom, 3'($urandom)));
      else if (pick < 92)
        pending.push_back(mk(mkh_pkg::OP_LOAD, x, $urandom, 3'($urandom)));
      else pending.push_back(mk(3'($urandom_range(7, 5)), x, $urandom, 3'($urandom)));
    end
  endtask

  initial begin
    logic [3:0] counts[8];
    longint top;
    tr_strain = 0; tr_stress = 0; tr_tangent = 0; tr_seg = 0;
    cm_strain = 0; cm_stress = 0; cm_tangent = 0;
    counts = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd8};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rejected points, extreme stresses, every operation
    write_count(4'd8);
    pending.push_back(mk(mkh_pkg::OP_LOAD, 32'sd0, 32'sd100, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_LOAD, 32'sh8000_0000, 32'sd100, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_LOAD, 32'sh0000_0001, 32'sh8000_0000, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_LOAD, 32'sh0100_0000, 32'sh7FFF_FFFF, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_LOAD, 32'sh0100_0000, 32'sd5000, 3'd1));
    for (int i = 0; i < NSEG; i++)
      pending.push_back(mk(mkh_pkg::OP_LOAD, 32'((i + 1) * 32'h0100_0000),
                           32'((i + 1) * 4000 - i * i * 300), 3'(i)));
    pending.push_back(mk(mkh_pkg::OP_LOAD, 32'sh0300_0000, 32'sd1, 3'd3));
    pending.push_back(mk(mkh_pkg::OP_TRIAL, 32'sh7FFF_FFFF, 32'sd0, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_TRIAL, 32'sh7FFF_FFFF, 32'sd0, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_COMMIT, 32'sd0, 32'sd0, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_TRIAL, 32'sh8000_0000, 32'sd0, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_REVERT_LAST, 32'sd0, 32'sd0, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_TRIAL, 32'sh0080_0000, 32'sd0, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_COMMIT, 32'sd0, 32'sd0, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_TRIAL, -32'sh0500_0000, 32'sd0, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_COMMIT, 32'sd0, 32'sd0, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_REVERT_START, 32'sd0, 32'sd0, 3'd0));
    pending.push_back(mk(3'd5, 32'sd0, 32'sd0, 3'd0));
    pending.push_back(mk(3'd6, 32'sd0, 32'sd0, 3'd0));
    pending.push_back(mk(3'd7, -32'sd1, -32'sd1, 3'd7));
    pending.push_back(mk(mkh_pkg::OP_TRIAL, 32'sh0600_0000, 32'sd0, 3'd0));
    settle();

    // shrink below the active segment before committing
    write_count(4'd2);
    pending.push_back(mk(mkh_pkg::OP_COMMIT, 32'sd0, 32'sd0, 3'd0));
    pending.push_back(mk(mkh_pkg::OP_LOAD, 32'sh0100_0000, 32'sd10, 3'd7));
    settle();

    foreach (counts[p]) begin
      write_count(counts[p]);
      queue_backbone(seg_limit(), top);
      queue_random(72);
      settle();
    end

    if (fail_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
